// ===== rtl/glyph_atlas_text_layout_assert.svh =====
// Assertion macros shared by the checker of the text layout block.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef GLYPH_ATLAS_TEXT_LAYOUT_ASSERT_SVH
`define GLYPH_ATLAS_TEXT_LAYOUT_ASSERT_SVH

// Consequent in the same cycle, ignored while reset is asserted.
`define GATL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the following cycle, ignored while reset is asserted.
`define GATL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent in the following cycle, checked through reset as well.
`define GATL_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gatl_pkg.sv =====
`timescale 1ns / 1ps

package gatl_pkg;

  localparam int unsigned GLYPH_SIZE_DEFAULT = 16;
  localparam logic [3:0]  LETTER_GAP_RESET   = 4'd4;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_t;

  // Character codes of the escape sequences.
  localparam logic [15:0] CODE_BACKSLASH = 16'd92;
  localparam logic [15:0] CODE_NEWLINE   = 16'd110;
  localparam logic [15:0] CODE_TAB       = 16'd116;

  // Glyph ranges.
  localparam logic [15:0] LATIN_LO     = 16'd32;
  localparam logic [15:0] LATIN_HI     = 16'd126;
  localparam logic [15:0] LATIN_EXT_LO = 16'd161;
  localparam logic [15:0] LATIN_EXT_HI = 16'd255;
  localparam logic [15:0] CODE_ELLIPSIS = 16'd8230;
  localparam logic [15:0] JP_LO        = 16'd12288;
  localparam logic [15:0] JP_HI        = 16'd12543;
  localparam logic [15:0] FW_LO        = 16'd65281;
  localparam logic [15:0] FW_HI        = 16'd65519;
  localparam logic [15:0] KANA_LO      = 16'd65377;
  localparam logic [15:0] KANA_HI      = 16'd65439;

  // Tile row offsets of the japanese sheet.
  localparam logic [11:0] ELLIPSIS_ROW  = 12'd16;
  localparam logic [11:0] JP_ROW_OFFSET = 12'd768;
  localparam logic [11:0] FW_ROW_OFFSET = 12'd4064;

endpackage

// ===== rtl/glyph_atlas_text_layout.sv =====
`timescale 1ns / 1ps

// Glyph atlas text layout.
// Character commands arrive on the s_ stream (command in s_tuser, end of string
// in s_tlast) and each drawn glyph leaves on the m_ stream as a tile description
// for the latin (m_tuser = 0) or japanese (m_tuser = 1) font sheet, with m_tlast
// marking the final glyph caused by an input transaction. The letter gap is set
// through the cfg_ channel, which is always ready.
// Loads and begins give no glyph. A glyph is made from the input register and
// loaded into the output register. One item is taken per cycle unless the
// output stalls; a drawable character after a held backslash waits while the
// backslash is drawn, as both glyphs share the output register and the decoder.
// Width table: a 256-entry memory written when a load is accepted and read at
// the low byte of the character code on every accepted item. A valid bit per
// entry, cleared by reset, makes unwritten entries read as the glyph size, so
// the block is ready straight after reset with no clearing pass.
// Reset (synchronous, active high) clears the pen, the origin, the pending
// backslash, the letter gap (back to 4) and both pipeline registers.
// When the receiver stalls the output register holds its glyph, an item in the
// input register that draws a glyph waits, and s_tready falls while it waits.
module glyph_atlas_text_layout #(
  parameter int unsigned GLYPH_SIZE = gatl_pkg::GLYPH_SIZE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration channel: cfg_data is letter_gap.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: origin_x[15:0], origin_y[31:16], char_code[47:32],
  // width_index[55:48], width_value[61:56], zero padding[63:62].
  input  logic [63:0] s_tdata,
  // s_tuser from bit 0: command[1:0].
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata from bit 0: src_x[9:0], src_y[19:10], src_width[25:20],
  // dest_x[41:26], dest_y[57:42], zero padding[63:58].
  output logic [63:0] m_tdata,
  // m_tuser from bit 0: sheet_select.
  output logic        m_tuser,
  output logic        m_tlast
);

  import gatl_pkg::*;

  localparam logic [5:0]  FULL_W  = 6'(GLYPH_SIZE);
  localparam logic [5:0]  HALF_W  = 6'(GLYPH_SIZE / 2);
  localparam logic [15:0] TAB_ADV = 16'(2 * GLYPH_SIZE);

  function automatic logic code_drawable(input logic [15:0] c);
    return (c inside {[LATIN_LO:LATIN_HI], [LATIN_EXT_LO:LATIN_EXT_HI],
                      [JP_LO:JP_HI], [FW_LO:FW_HI]}) || (c == CODE_ELLIPSIS);
  endfunction

  // Layout state.
  logic [15:0] pen_column, pen_column_next;
  logic [11:0] pen_row, pen_row_next;
  logic [15:0] base_x, base_x_next;
  logic [15:0] base_y, base_y_next;
  logic        backslash_pending, backslash_pending_next;
  logic [3:0]  letter_gap;

  // Width table, with a valid bit per entry and a copy of the backslash entry,
  // which is needed at a fixed address alongside the read of the current code.
  logic [5:0]   width_mem [256];
  logic [255:0] width_valid;
  logic [5:0]   bs_width;

  // Input register.
  logic        a_valid;
  cmd_t        a_cmd;
  logic [15:0] a_origin_x;
  logic [15:0] a_origin_y;
  logic [15:0] a_char;
  logic        a_last;
  logic [5:0]  a_rd_data;
  logic        a_rd_valid;

  // Output register.
  logic        o_valid;
  logic        o_sheet;
  logic [9:0]  o_src_x;
  logic [9:0]  o_src_y;
  logic [5:0]  o_src_width;
  logic [15:0] o_dest_x;
  logic [15:0] o_dest_y;
  logic        o_last;

  logic       s_accept;
  logic       can_emit;
  logic       emit;
  logic       pop;
  logic       glyph_last;
  logic       o_load;
  logic [7:0] s_width_index;

  // Glyph decoder, shared by the flushed backslash and the current code.
  logic [15:0] gw;
  logic [5:0]  gw_width;
  logic        g_latin, g_ellipsis, g_jp, g_fw, g_kana, g_draw;
  logic        g_sheet;
  logic [11:0] g_row;
  logic [5:0]  g_sw;
  logic [9:0]  g_sx, g_sy;
  logic [15:0] g_col, g_col_after, g_dest_x, g_dest_y;

  logic char_held;
  logic char_draws;
  logic second_glyph;

  assign s_accept      = s_tvalid && s_tready;
  assign s_width_index = s_tdata[55:48];
  assign can_emit      = !o_valid || m_tready;
  assign o_load        = emit && can_emit;
  assign s_tready      = !a_valid || pop;
  assign cfg_ready     = 1'b1;

  assign gw       = backslash_pending ? CODE_BACKSLASH : a_char;
  assign gw_width = backslash_pending ? bs_width : (a_rd_valid ? a_rd_data : FULL_W);

  assign g_latin    = gw inside {[LATIN_LO:LATIN_HI], [LATIN_EXT_LO:LATIN_EXT_HI]};
  assign g_ellipsis = (gw == CODE_ELLIPSIS);
  assign g_jp       = gw inside {[JP_LO:JP_HI]};
  assign g_fw       = gw inside {[FW_LO:FW_HI]};
  assign g_kana     = gw inside {[KANA_LO:KANA_HI]};
  assign g_draw     = g_latin || g_ellipsis || g_jp || g_fw;

  always_comb begin
    g_sheet = 1'b1;
    g_row   = gw[15:4];
    g_sw    = FULL_W;
    if (g_latin) begin
      g_sheet = 1'b0;
      g_sw    = gw_width;
    end else if (g_ellipsis) begin
      g_row = ELLIPSIS_ROW;
    end else if (g_jp) begin
      g_row = gw[15:4] - JP_ROW_OFFSET;
    end else if (g_fw) begin
      g_row = gw[15:4] - FW_ROW_OFFSET;
      if (g_kana) begin
        g_sw = HALF_W;
      end
    end
  end

  // The advance always equals the glyph width; latin glyphs take the gap first.
  assign g_sx        = g_ellipsis ? 10'd0 : 10'(gw[3:0] * GLYPH_SIZE);
  assign g_sy        = 10'(g_row * GLYPH_SIZE);
  assign g_col       = g_latin ? pen_column + {12'd0, letter_gap} : pen_column;
  assign g_col_after = g_col + {10'd0, g_sw};
  assign g_dest_x    = base_x + g_col;
  assign g_dest_y    = base_y + 16'(pen_row * GLYPH_SIZE);

  assign char_held    = (a_char == CODE_BACKSLASH) && !a_last;
  assign char_draws   = code_drawable(a_char);
  assign second_glyph = char_draws && !char_held;

  always_comb begin
    emit                   = 1'b0;
    pop                    = 1'b0;
    glyph_last             = 1'b1;
    pen_column_next        = pen_column;
    pen_row_next           = pen_row;
    base_x_next            = base_x;
    base_y_next            = base_y;
    backslash_pending_next = backslash_pending;
    if (a_valid) begin
      case (a_cmd)
        CMD_BEGIN: begin
          pop                    = 1'b1;
          base_x_next            = a_origin_x;
          base_y_next            = a_origin_y;
          pen_column_next        = '0;
          pen_row_next           = '0;
          backslash_pending_next = 1'b0;
        end
        CMD_LOAD: begin
          // The table was written when the item was accepted.
          pop = 1'b1;
        end
        CMD_CHAR: begin
          if (backslash_pending) begin
            if (a_char == CODE_NEWLINE) begin
              pop                    = 1'b1;
              pen_row_next           = pen_row + 12'd1;
              pen_column_next        = '0;
              backslash_pending_next = 1'b0;
            end else if (a_char == CODE_TAB) begin
              pop                    = 1'b1;
              pen_column_next        = pen_column + TAB_ADV;
              backslash_pending_next = 1'b0;
            end else begin
              // Draw the held backslash; an unheld drawable code stays to follow.
              emit       = 1'b1;
              glyph_last = !second_glyph;
              if (can_emit) begin
                pen_column_next        = g_col_after;
                backslash_pending_next = second_glyph ? 1'b0 : char_held;
                pop                    = !second_glyph;
              end
            end
          end else if (char_held) begin
            pop                    = 1'b1;
            backslash_pending_next = 1'b1;
          end else if (g_draw) begin
            emit = 1'b1;
            if (can_emit) begin
              pen_column_next = g_col_after;
              pop             = 1'b1;
            end
          end else begin
            pop = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid           <= 1'b0;
      o_valid           <= 1'b0;
      pen_column        <= '0;
      pen_row           <= '0;
      base_x            <= '0;
      base_y            <= '0;
      backslash_pending <= 1'b0;
      letter_gap        <= LETTER_GAP_RESET;
      width_valid       <= '0;
      bs_width          <= FULL_W;
    end else begin
      if (s_tready) begin
        a_valid <= s_tvalid;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      pen_column        <= pen_column_next;
      pen_row           <= pen_row_next;
      base_x            <= base_x_next;
      base_y            <= base_y_next;
      backslash_pending <= backslash_pending_next;
      if (cfg_valid && cfg_ready) begin
        letter_gap <= cfg_data;
      end
      if (s_accept && (s_tuser == CMD_LOAD)) begin
        width_valid[s_width_index] <= 1'b1;
        if ({8'd0, s_width_index} == CODE_BACKSLASH) begin
          bs_width <= s_tdata[61:56];
        end
      end
    end
  end

  // Width table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (s_accept && (s_tuser == CMD_LOAD)) begin
      width_mem[s_width_index] <= s_tdata[61:56];
    end
    if (s_accept) begin
      a_rd_data <= width_mem[s_tdata[39:32]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_cmd      <= cmd_t'(s_tuser);
      a_origin_x <= s_tdata[15:0];
      a_origin_y <= s_tdata[31:16];
      a_char     <= s_tdata[47:32];
      a_last     <= s_tlast;
      a_rd_valid <= width_valid[s_tdata[39:32]];
    end
    if (o_load) begin
      o_sheet     <= g_sheet;
      o_src_x     <= g_sx;
      o_src_y     <= g_sy;
      o_src_width <= g_sw;
      o_dest_x    <= g_dest_x;
      o_dest_y    <= g_dest_y;
      o_last      <= glyph_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {6'd0, o_dest_y, o_dest_x, o_src_width, o_src_y, o_src_x};
  assign m_tuser  = o_sheet;
  assign m_tlast  = o_last;

endmodule

// ===== rtl/gatl_checker.sv =====
`timescale 1ns / 1ps
`include "glyph_atlas_text_layout_assert.svh"

module gatl_checker #(
  parameter int unsigned GLYPH_SIZE = gatl_pkg::GLYPH_SIZE_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  import gatl_pkg::*;

  localparam logic [5:0] FULL_W = 6'(GLYPH_SIZE);
  localparam logic [5:0] HALF_W = 6'(GLYPH_SIZE / 2);

  // The output register is empty straight after reset.
  `GATL_ASSERT_NEXT_RST(a_reset_empty, rst, !m_tvalid, "output valid after reset")

  // A glyph that is not the last of its input is followed at once by the next.
  `GATL_ASSERT_NEXT(a_second_follows, m_tvalid && m_tready && !m_tlast, m_tvalid,
                    "second glyph did not follow")

  // Japanese tiles are always a full or a half glyph wide.
  `GATL_ASSERT_SAME(a_jp_width, m_tvalid && m_tuser,
                    (m_tdata[25:20] == FULL_W) || (m_tdata[25:20] == HALF_W),
                    "japanese glyph with proportional width")

  // A stalled glyph stays in place.
  `GATL_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast),
                    "stalled glyph changed")

endmodule

bind glyph_atlas_text_layout gatl_checker #(.GLYPH_SIZE(GLYPH_SIZE)) u_gatl_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast)
);

// ===== tb/glyph_atlas_text_layout_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, input and output channels of the text layout block.
// It predicts the glyphs that each accepted input transaction causes.
// It compares every output transaction, field by field, with the oldest glyph still owed.
module glyph_atlas_text_layout_checker #(
  parameter int unsigned GLYPH_SIZE = gatl_pkg::GLYPH_SIZE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int unsigned fail_count,
  output int unsigned glyphs_pending,
  output int unsigned glyphs_checked
);
  import gatl_pkg::*;

  typedef struct {
    logic        sheet;
    logic [9:0]  src_x;
    logic [9:0]  src_y;
    logic [5:0]  src_width;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic        last;
  } glyph_t;

  glyph_t      owed_glyphs[$];
  logic [15:0] pen_col;
  logic [11:0] pen_row;
  logic [15:0] org_x;
  logic [15:0] org_y;
  logic        held_bs;
  logic [3:0]  gap;
  logic [5:0]  width_of[256];

  // Cuts one glyph from the sheets and moves the pen past it.
  // It returns 0 for a code that has no tile.
  function automatic bit lay_glyph(input logic [15:0] code, output glyph_t g);
    int unsigned sx;
    int unsigned sy;
    int unsigned sw;
    int unsigned adv;
    g.sheet = 1'b1;
    g.last  = 1'b0;
    sx  = 32'(code[3:0]) * GLYPH_SIZE;
    sy  = 0;
    sw  = GLYPH_SIZE;
    adv = GLYPH_SIZE;
    if ((code >= LATIN_LO && code <= LATIN_HI) ||
        (code >= LATIN_EXT_LO && code <= LATIN_EXT_HI)) begin
      g.sheet = 1'b0;
      sy      = 32'(code[15:4]) * GLYPH_SIZE;
      sw      = 32'(width_of[code[7:0]]);
      adv     = sw;
      pen_col = pen_col + 16'(gap);
    end else if (code == CODE_ELLIPSIS) begin
      sx = 0;
      sy = 32'(ELLIPSIS_ROW) * GLYPH_SIZE;
    end else if (code >= JP_LO && code <= JP_HI) begin
      sy = (32'(code[15:4]) - 32'(JP_ROW_OFFSET)) * GLYPH_SIZE;
    end else if (code >= FW_LO && code <= FW_HI) begin
      sy = (32'(code[15:4]) - 32'(FW_ROW_OFFSET)) * GLYPH_SIZE;
      if (code >= KANA_LO && code <= KANA_HI) begin
        sw  = GLYPH_SIZE / 2;
        adv = GLYPH_SIZE / 2;
      end
    end else begin
      return 1'b0;
    end
    g.src_x     = 10'(sx);
    g.src_y     = 10'(sy);
    g.src_width = 6'(sw);
    g.dest_x    = org_x + pen_col;
    g.dest_y    = org_y + 16'(32'(pen_row) * GLYPH_SIZE);
    pen_col     = pen_col + 16'(adv);
    return 1'b1;
  endfunction

  task automatic predict_item();
    logic [15:0] code;
    glyph_t      held_glyph;
    glyph_t      this_glyph;
    bit          drew_held;
    bit          drew_this;
    code      = s_tdata[47:32];
    drew_held = 1'b0;
    drew_this = 1'b0;
    case (s_tuser)
      CMD_BEGIN: begin
        org_x   = s_tdata[15:0];
        org_y   = s_tdata[31:16];
        pen_col = '0;
        pen_row = '0;
        held_bs = 1'b0;
      end
      CMD_LOAD: width_of[s_tdata[55:48]] = s_tdata[61:56];
      CMD_CHAR: begin
        if (held_bs && code == CODE_NEWLINE) begin
          held_bs = 1'b0;
          pen_row = pen_row + 12'd1;
          pen_col = '0;
        end else if (held_bs && code == CODE_TAB) begin
          held_bs = 1'b0;
          pen_col = pen_col + 16'(2 * GLYPH_SIZE);
        end else begin
          // A held backslash that starts no escape is drawn ahead of the new code.
          if (held_bs) begin
            held_bs   = 1'b0;
            drew_held = lay_glyph(CODE_BACKSLASH, held_glyph);
          end
          if (code == CODE_BACKSLASH && !s_tlast)
            held_bs = 1'b1;
          else
            drew_this = lay_glyph(code, this_glyph);
          if (drew_this)
            this_glyph.last = 1'b1;
          else if (drew_held)
            held_glyph.last = 1'b1;
          if (drew_held)
            owed_glyphs.push_back(held_glyph);
          if (drew_this)
            owed_glyphs.push_back(this_glyph);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_glyph();
    glyph_t want;
    if (owed_glyphs.size() == 0) begin
      $display("%0t: glyph with none expected, actual tdata %h tuser %b tlast %b",
               $time, m_tdata, m_tuser, m_tlast);
      fail_count++;
    end else begin
      want = owed_glyphs.pop_front();
      glyphs_checked++;
      check_field("sheet_select", 16'(want.sheet), 16'(m_tuser));
      check_field("src_x", 16'(want.src_x), 16'(m_tdata[9:0]));
      check_field("src_y", 16'(want.src_y), 16'(m_tdata[19:10]));
      check_field("src_width", 16'(want.src_width), 16'(m_tdata[25:20]));
      check_field("dest_x", want.dest_x, m_tdata[41:26]);
      check_field("dest_y", want.dest_y, m_tdata[57:42]);
      check_field("last_glyph", 16'(want.last), 16'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pen_col = '0;
      pen_row = '0;
      org_x   = '0;
      org_y   = '0;
      held_bs = 1'b0;
      gap     = LETTER_GAP_RESET;
      for (int i = 0; i < 256; i++)
        width_of[i] = 6'(GLYPH_SIZE);
      owed_glyphs.delete();
      fail_count     = 0;
      glyphs_checked = 0;
    end else begin
      if (m_tvalid && m_tready)
        check_glyph();
      if (cfg_valid && cfg_ready)
        gap = cfg_data;
      if (s_tvalid && s_tready)
        predict_item();
    end
    glyphs_pending <= owed_glyphs.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Top level of the text layout testbench.
// This module only makes stimulus and gives the verdict.
// The checker instance beside the block watches every channel, predicts the glyphs and
// keeps the failure count.
//
// The run goes through these stages:
//   - a short directed stretch covering the ends of each glyph range, undrawable codes,
//     every escape pair and the odd commands;
//   - four random phases, each with its own letter gap and idling pattern (none, sender
//     idle, receiver stalling, both);
//   - a long receiver hold-off while the sender keeps offering, so that the block fills
//     up and stalls its input;
//   - a wrap stage that pushes the pen column past its width.
module tb;
  import gatl_pkg::*;

  localparam int unsigned GLYPH_SIZE      = GLYPH_SIZE_DEFAULT;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned HOLD_CYCLES     = 300;
  // The widest latin glyph with the largest gap advances 78 pixels, so this many
  // run the pen column once past 16 bits.
  localparam int unsigned WRAP_CHARS      = 850;
  // The block has a two-register pipeline.
  // This many cycles covers any item that is still in flight but owes no glyph.
  localparam int unsigned SETTLE_CYCLES   = 8;
  // The longest correct quiet spell is the hold-off above; this is well clear of it.
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  // A wide latin letter, loaded with the largest width for the wrap stage.
  localparam logic [15:0] CODE_WIDE       = 16'd87;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int unsigned fail_count;
  int unsigned glyphs_pending;
  int unsigned glyphs_checked;

  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // The stimulus toggles hold_req to ask for one long hold-off.
  // The receiver process counts the hold-off out itself.
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  glyph_atlas_text_layout #(
    .GLYPH_SIZE(GLYPH_SIZE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  glyph_atlas_text_layout_checker #(
    .GLYPH_SIZE(GLYPH_SIZE)
  ) glyph_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .glyphs_pending(glyphs_pending),
    .glyphs_checked(glyphs_checked)
  );

  // Receiver. It normally stalls at random at the phase's rate. On request it holds off
  // until hold_left has counted down to zero.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_tready  <= 1'b0;
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog. It ends the run if no transaction of any kind completes before its quiet
  // counter reaches WATCHDOG_LIMIT.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // s_tdata layout from bit 0: origin_x, origin_y, char_code, width_index, width_value.
  function automatic logic [63:0] item_data(input logic [15:0] ox, input logic [15:0] oy,
                                            input logic [15:0] code, input logic [7:0] widx,
                                            input logic [5:0] wval);
    return {2'b00, wval, widx, code, oy, ox};
  endfunction

  function automatic logic [15:0] any16();
    return 16'($urandom);
  endfunction

  // Offers one input transaction and returns once it has been accepted.
  // Sender idle cycles are inserted ahead of it at the phase's rate.
  task automatic send_item(input logic [1:0] cmd, input logic [63:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= cmd;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (cmd != CMD_UNUSED)
      items_sent++;
  endtask

  // The fields a command does not use carry random noise throughout.
  task automatic send_char(input logic [15:0] code, input logic last);
    send_item(CMD_CHAR, item_data(any16(), any16(), code, 8'($urandom), 6'($urandom)), last);
  endtask

  task automatic send_begin(input logic [15:0] ox, input logic [15:0] oy);
    send_item(CMD_BEGIN, item_data(ox, oy, any16(), 8'($urandom), 6'($urandom)),
              1'($urandom));
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [5:0] val);
    send_item(CMD_LOAD, item_data(any16(), any16(), any16(), idx, val), 1'($urandom));
  endtask

  // Mostly drawable codes, weighted towards latin. The remainder are mostly undrawable
  // codes from below, between and above the ranges, the rest fully random codes.
  function automatic logic [15:0] pick_code();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 8)
      return $urandom_range(1) ? 16'($urandom_range(LATIN_LO, LATIN_HI))
                               : 16'($urandom_range(LATIN_EXT_LO, LATIN_EXT_HI));
    else if (r == 8)
      return CODE_ELLIPSIS;
    else if (r < 11)
      return 16'($urandom_range(JP_LO, JP_HI));
    else if (r < 13)
      return 16'($urandom_range(FW_LO, FW_HI));
    else if (r < 15)
      return 16'($urandom_range(KANA_LO, KANA_HI));
    else if (r == 15)
      return 16'($urandom_range(LATIN_LO - 1));
    else if (r == 16)
      return 16'($urandom_range(LATIN_HI + 1, LATIN_EXT_LO - 1));
    else if (r == 17)
      return 16'($urandom_range(FW_HI + 1, 16'hFFFF));
    return any16();
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return any16();
    endcase
  endfunction

  // One random step. Mostly this sends plain characters and escape pairs with random
  // content. It also sends some broken escapes, table loads, restarts and ignored commands.
  task automatic send_random();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_begin(pick_coord(), pick_coord());
    end else if (pick < 8) begin
      send_load($urandom_range(3) != 0 ? 8'(pick_code()) : 8'($urandom), 6'($urandom));
    end else if (pick < 10) begin
      send_item(CMD_UNUSED, {2'b00, 30'($urandom), 32'($urandom)}, 1'($urandom));
    end else if (pick < 26) begin
      send_char(CODE_BACKSLASH, 1'b0);
      case ($urandom_range(6))
        0, 1: send_char(CODE_NEWLINE, 1'($urandom));
        2, 3: send_char(CODE_TAB, 1'($urandom));
        4:    send_char(pick_code(), 1'($urandom));
        5: begin
          // A table load must leave the held backslash in place.
          send_load(8'(CODE_BACKSLASH), 6'($urandom));
          send_char(pick_code(), 1'($urandom));
        end
        default: send_begin(pick_coord(), pick_coord());
      endcase
    end else begin
      send_char(pick_code(), $urandom_range(7) == 0);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at)
      send_random();
  endtask

  // Lets every owed glyph arrive, then lets items that owe none drain from the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (glyphs_pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The letter gap changes only while the block is idle.
  task automatic write_gap(input logic [3:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    do @(posedge clk); while (rst);

    // Directed stretch. It runs with the letter gap still at its reset value.
    send_begin(16'h8000, 16'h7FFF);
    send_load(8'hFF, 6'd63);
    send_char(LATIN_LO, 1'b0);
    send_char(LATIN_HI, 1'b0);
    send_char(LATIN_EXT_LO, 1'b0);
    send_char(LATIN_EXT_HI, 1'b0);
    send_char(16'd0, 1'b1);
    send_char(LATIN_HI + 16'd1, 1'b0);
    send_char(CODE_ELLIPSIS, 1'b0);
    send_char(JP_LO, 1'b0);
    send_char(JP_HI, 1'b0);
    send_char(FW_LO, 1'b0);
    send_char(FW_HI, 1'b0);
    send_char(KANA_LO, 1'b0);
    send_char(KANA_HI, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(CODE_BACKSLASH, 1'b0);
    send_char(CODE_NEWLINE, 1'b0);
    send_char(CODE_BACKSLASH, 1'b0);
    send_char(CODE_TAB, 1'b0);
    // A backslash followed by another backslash draws the first and holds the second.
    send_char(CODE_BACKSLASH, 1'b0);
    send_char(CODE_BACKSLASH, 1'b0);
    // At the end of a string the held backslash and the closing one are both drawn.
    send_char(CODE_BACKSLASH, 1'b1);
    // A restart discards a held backslash.
    send_char(CODE_BACKSLASH, 1'b0);
    send_begin(16'h7FFF, 16'h8000);
    // A zero-width backslash is loaded under a held one, and then it is drawn.
    send_char(CODE_BACKSLASH, 1'b0);
    send_load(8'(CODE_BACKSLASH), 6'd0);
    send_char(16'd120, 1'b0);
    send_item(CMD_UNUSED, {2'b00, 30'($urandom), 32'($urandom)}, 1'b0);

    // Random phases. Each phase has its own idling pattern and letter gap.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          write_gap(4'd0);
        end
        1: begin
          send_idle_pct = 53;
          recv_stall_pct <= 0;
          write_gap(4'd15);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 53;
          write_gap(4'($urandom));
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct <= 26;
          write_gap(4'($urandom));
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    // Long hold-off. The receiver stops while the sender keeps offering characters.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    write_gap(4'd7);
    hold_req <= ~hold_req;
    repeat (60) send_char(pick_code(), 1'b0);

    // Wrap stage. The widest glyphs with the largest gap run the pen column past
    // 16 bits.
    recv_stall_pct <= 26;
    write_gap(4'd15);
    send_begin(16'h7FFF, 16'h7FF0);
    send_load(8'(CODE_WIDE), 6'd63);
    repeat (WRAP_CHARS) send_char(CODE_WIDE, 1'b0);
    repeat (20) send_random();

    settle();
    $display("Covered %0d input transactions: directed cases, four idling phases, a long",
             items_sent);
    $display("output hold-off and pen wrap; %0d glyph transactions compared.", glyphs_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
